[rtl/core/grid_height_model_vote_and_check_unit_macros.svh]
// Assertion macros for the grid height model. They expect clk and rst_n in scope.
`ifndef GRID_HEIGHT_MODEL_VOTE_AND_CHECK_UNIT_MACROS_SVH
`define GRID_HEIGHT_MODEL_VOTE_AND_CHECK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GHM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GHM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GHM_ASSERT(lbl, prop, msg)
`define GHM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/core/ghm_pkg.sv]
`default_nettype none
package ghm_pkg;

    localparam int HEIGHT_W = 20;
    localparam int COUNT_W  = 8;
    localparam int MAP_NUM_W = 20;
    localparam int MAP_DEN_W = 13;
    localparam int MAP_Q_W   = 7;
    localparam int MEAN_NUM_W = 29;

    localparam logic OP_VOTE  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [1:0] VERDICT_NOT_SURE = 2'd0;
    localparam logic [1:0] VERDICT_GOOD     = 2'd1;
    localparam logic [1:0] VERDICT_BAD      = 2'd2;

    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_LEARNING_RATE = 3'd2;
    localparam logic [2:0] CFG_HEIGHT_SPREAD = 3'd3;

    typedef struct packed {
        logic                  filled;
        logic [COUNT_W-1:0]    count;
        logic [HEIGHT_W-1:0]   height;
    } cell_t;

endpackage
`default_nettype wire

[rtl/core/grid_height_model_vote_and_check_unit.sv]
`default_nettype none
`include "grid_height_model_vote_and_check_unit_macros.svh"
// Grid height model: learns person heights over a grid of image cells.
// Command channel: an item transfer happens at a clock edge where start is high
// and busy is low. The item is an opcode and a box. A vote updates the foot
// cell and its 3x3 neighborhood; a check reports one result.
// Result channel: done is high for exactly one cycle with verdict and
// expected_height valid. The receiver cannot stall, so a result is simply
// presented once and then dropped. Votes produce no result.
// Configuration: cfg_we writes cfg_data to register cfg_index at once.
// Indexes beyond the register list are ignored.
// Sequence: the foot point is mapped to a row and a column by two bit-serial
// dividers. A check then reads its cell in S_RD and S_EVAL and returns its
// result from S_EVAL for an empty cell, or after S_CHK2 and S_CHK3 for a
// filled one. A vote visits nine cells one at a time through the single cell
// memory: S_RD, S_EVAL and S_WR for an empty cell, with S_MUL2 and S_EMA added
// for a settled cell, or S_MNUM, the serial divider S_MDIV and S_EMA for a
// running-mean cell. Busy stays high until the ninth cell is written.
// Reset: after rst_n releases, a clearing pass writes every cell of the
// memory, one per cycle, with busy high.
module grid_height_model_vote_and_check_unit #(
    parameter int GRID_ROWS    = 8,
    parameter int GRID_COLS    = 8,
    parameter int SETTLE_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        opcode,
    input  wire logic [11:0] box_left,
    input  wire logic [11:0] box_top,
    input  wire logic [11:0] box_width,
    input  wire logic [11:0] box_height,
    output logic             done,
    output logic [1:0]       verdict,
    output logic [19:0]      expected_height
);

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int HW    = ghm_pkg::HEIGHT_W;
    localparam int NW    = ghm_pkg::MAP_NUM_W;
    localparam int DW    = ghm_pkg::MAP_DEN_W;
    localparam int QW    = ghm_pkg::MAP_Q_W;
    localparam int MW    = ghm_pkg::MEAN_NUM_W;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_MAP   = 12'b0000_0000_0100,
        S_RD    = 12'b0000_0000_1000,
        S_EVAL  = 12'b0000_0001_0000,
        S_MUL2  = 12'b0000_0010_0000,
        S_EMA   = 12'b0000_0100_0000,
        S_MNUM  = 12'b0000_1000_0000,
        S_MDIV  = 12'b0001_0000_0000,
        S_WR    = 12'b0010_0000_0000,
        S_CHK2  = 12'b0100_0000_0000,
        S_CHK3  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;

    logic [11:0] frame_width_reg, frame_height_reg;
    logic [15:0] learning_rate_reg, height_spread_reg;

    logic        op_reg;
    logic [HW-1:0] hq_reg;

    logic [NW-1:0] row_rem_reg, col_rem_reg;
    logic [DW-1:0] row_den_reg, col_den_reg;
    logic [QW-1:0] row_q_reg, col_q_reg;
    logic          row_sat_reg, col_sat_reg;
    logic [2:0]    map_k_reg;

    logic [1:0]    di_reg, dj_reg;
    logic [CW-1:0] clr_idx_reg;

    ghm_pkg::cell_t mem [CELLS];
    ghm_pkg::cell_t rd_reg;

    logic [35:0]   prod_a_reg;
    logic [45:0]   prod_b_reg;
    logic [MW-1:0] mrem_reg;
    logic [8:0]    mden_reg;
    logic [HW-1:0] mq_reg;
    logic [4:0]    mk_reg;

    logic [HW-1:0]      h_new_reg;
    logic [7:0]         cnt_new_reg;

    logic        done_reg;
    logic [1:0]  verdict_reg;
    logic [HW-1:0] exp_reg;

    // Mapping results, clamped to the grid.
    logic [QW-1:0] row_c, col_c;
    logic [AW-1:0] cell_idx;
    logic          accept;

    // Datapath helpers.
    logic [NW:0]   row_trial, col_trial;
    logic [MW-1:0] m_trial;
    logic [HW-1:0] diff;
    logic [8:0]    n_inc;
    logic [7:0]    cnt_sat_inc;
    logic [37:0]   ema_sum;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign verdict = verdict_reg;
    assign expected_height = exp_reg;

    always_comb
    begin
        if (row_sat_reg || (int'(row_q_reg) > GRID_ROWS - 1))
            row_c = QW'(GRID_ROWS - 1);
        else
            row_c = row_q_reg;
        if (col_sat_reg || (int'(col_q_reg) > GRID_COLS - 1))
            col_c = QW'(GRID_COLS - 1);
        else
            col_c = col_q_reg;
    end

    // Neighbor address, clamped at the grid edges.
    always_comb
    begin
        int tr;
        int tc;
        tr = int'(row_c) + int'(di_reg) - 1;
        tc = int'(col_c) + int'(dj_reg) - 1;
        if (tr < 0)
            tr = 0;
        if (tr > GRID_ROWS - 1)
            tr = GRID_ROWS - 1;
        if (tc < 0)
            tc = 0;
        if (tc > GRID_COLS - 1)
            tc = GRID_COLS - 1;
        cell_idx = AW'(tr * GRID_COLS + tc);
    end

    assign row_trial = (NW+1)'(row_den_reg) << map_k_reg;
    assign col_trial = (NW+1)'(col_den_reg) << map_k_reg;
    assign m_trial   = MW'(mden_reg) << mk_reg;
    assign diff = (rd_reg.height > hq_reg) ? (rd_reg.height - hq_reg)
                                           : (hq_reg - rd_reg.height);
    assign n_inc = 9'(rd_reg.count) + 9'd1;
    assign cnt_sat_inc = (rd_reg.count == 8'hFF) ? 8'hFF : (rd_reg.count + 8'd1);
    assign ema_sum = 38'(prod_a_reg) + 38'(prod_b_reg[36:0]) + 38'd32768;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= 12'd640;
            frame_height_reg  <= 12'd480;
            learning_rate_reg <= 16'd4096;
            height_spread_reg <= 16'd6554;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ghm_pkg::CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[11:0];
                ghm_pkg::CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[11:0];
                ghm_pkg::CFG_LEARNING_RATE: learning_rate_reg <= cfg_data;
                ghm_pkg::CFG_HEIGHT_SPREAD: height_spread_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cell memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mem[clr_idx_reg[AW-1:0]] <= '0;
        else if (state_reg == S_WR)
            mem[cell_idx] <= '{filled: 1'b1, count: cnt_new_reg, height: h_new_reg};
        if (state_reg == S_RD)
            rd_reg <= mem[cell_idx];
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
            map_k_reg   <= '0;
            mk_reg      <= '0;
            di_reg      <= '0;
            dj_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + CW'(1);
                    if (clr_idx_reg == CW'(CELLS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        map_k_reg <= 3'd7;
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    map_k_reg <= map_k_reg - 3'd1;
                    if (map_k_reg == 3'd0)
                    begin
                        if (op_reg == ghm_pkg::OP_CHECK)
                        begin
                            di_reg <= 2'd1;
                            dj_reg <= 2'd1;
                        end
                        else
                        begin
                            di_reg <= 2'd0;
                            dj_reg <= 2'd0;
                        end
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (op_reg == ghm_pkg::OP_CHECK)
                    begin
                        if (!rd_reg.filled)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_CHK2;
                    end
                    else if (!rd_reg.filled)
                        state_reg <= S_WR;
                    else if (int'(rd_reg.count) > SETTLE_COUNT)
                        state_reg <= S_MUL2;
                    else
                        state_reg <= S_MNUM;
                end
                S_MUL2:
                    state_reg <= S_EMA;
                S_EMA:
                    state_reg <= S_WR;
                S_MNUM:
                begin
                    mk_reg    <= 5'd19;
                    state_reg <= S_MDIV;
                end
                S_MDIV:
                begin
                    mk_reg <= mk_reg - 5'd1;
                    if (mk_reg == 5'd0)
                        state_reg <= S_EMA;
                end
                S_WR:
                begin
                    if (dj_reg == 2'd2)
                    begin
                        dj_reg <= 2'd0;
                        di_reg <= di_reg + 2'd1;
                    end
                    else
                        dj_reg <= dj_reg + 2'd1;
                    if (di_reg == 2'd2 && dj_reg == 2'd2)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_RD;
                end
                S_CHK2:
                    state_reg <= S_CHK3;
                S_CHK3:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg      <= opcode;
                    hq_reg      <= {box_height, 8'd0};
                    row_rem_reg <= NW'(13'(box_top) + 13'(box_height)) * NW'(GRID_ROWS);
                    col_rem_reg <= NW'(14'({box_left, 1'b0}) + 14'(box_width))
                                   * NW'(GRID_COLS);
                    row_den_reg <= DW'(frame_height_reg);
                    col_den_reg <= {frame_width_reg, 1'b0};
                    row_q_reg   <= '0;
                    col_q_reg   <= '0;
                    row_sat_reg <= 1'b0;
                    col_sat_reg <= 1'b0;
                end
            end
            S_MAP:
            begin
                // The top step only detects a quotient out of range.
                if ((NW+1)'(row_rem_reg) >= row_trial)
                begin
                    if (map_k_reg == 3'd7)
                        row_sat_reg <= 1'b1;
                    else
                    begin
                        row_rem_reg <= NW'((NW+1)'(row_rem_reg) - row_trial);
                        row_q_reg[map_k_reg] <= 1'b1;
                    end
                end
                if ((NW+1)'(col_rem_reg) >= col_trial)
                begin
                    if (map_k_reg == 3'd7)
                        col_sat_reg <= 1'b1;
                    else
                    begin
                        col_rem_reg <= NW'((NW+1)'(col_rem_reg) - col_trial);
                        col_q_reg[map_k_reg] <= 1'b1;
                    end
                end
            end
            S_EVAL:
            begin
                if (op_reg == ghm_pkg::OP_CHECK)
                begin
                    verdict_reg <= ghm_pkg::VERDICT_NOT_SURE;
                    exp_reg     <= rd_reg.filled ? rd_reg.height : '0;
                    prod_a_reg  <= 36'(diff) * 36'(rd_reg.count);
                    prod_b_reg  <= 46'(10'(rd_reg.count) * 10'd3 + 10'd10)
                                   * 46'(height_spread_reg);
                end
                else if (!rd_reg.filled)
                begin
                    h_new_reg   <= hq_reg;
                    cnt_new_reg <= cnt_sat_inc;
                end
                else if (int'(rd_reg.count) > SETTLE_COUNT)
                begin
                    prod_a_reg  <= 36'(learning_rate_reg) * 36'(hq_reg);
                    cnt_new_reg <= rd_reg.count;
                end
                else
                begin
                    prod_a_reg  <= 36'(rd_reg.count) * 36'(rd_reg.height);
                    cnt_new_reg <= cnt_sat_inc;
                    mden_reg    <= n_inc;
                end
            end
            S_MUL2:
                prod_b_reg <= 46'(17'd65536 - 17'(learning_rate_reg)) * 46'(rd_reg.height);
            S_EMA:
            begin
                if (int'(rd_reg.count) > SETTLE_COUNT)
                    h_new_reg <= ema_sum[35:16];
                else
                    h_new_reg <= mq_reg;
            end
            S_MNUM:
            begin
                mrem_reg <= MW'(hq_reg) + MW'(prod_a_reg[27:0]) + MW'(mden_reg[8:1]);
                mq_reg   <= '0;
            end
            S_MDIV:
            begin
                if (mrem_reg >= m_trial)
                begin
                    mrem_reg <= mrem_reg - m_trial;
                    mq_reg[mk_reg] <= 1'b1;
                end
            end
            S_CHK2:
                prod_b_reg <= 46'(prod_b_reg[25:0]) * 46'(rd_reg.height);
            S_CHK3:
                verdict_reg <= (46'({prod_a_reg[27:0], 16'd0}) < prod_b_reg)
                               ? ghm_pkg::VERDICT_GOOD : ghm_pkg::VERDICT_BAD;
            default: ;
        endcase
    end

    `GHM_ASSERT(a_state_onehot, $onehot(state_reg), "state register is not one-hot")
    `GHM_ASSERT(a_accept_busy, accept |=> busy, "accepted item did not raise busy")
    `GHM_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")
    `GHM_ASSERT(a_unsure_zero, (done && verdict == ghm_pkg::VERDICT_NOT_SURE) |-> (expected_height == '0), "empty cell result carries a height")

endmodule
`default_nettype wire

[tb/sv/tb_grid_height_model_vote_and_check_unit.sv]
`timescale 1ns / 1ps

// Testbench for the grid height model. A scoreboard class keeps its own copy
// of the height grid, vote counts and filled bits, replays every accepted vote
// and check, and queues the verdict and learned height each check must return.
// Results carry no back-pressure, so they are sampled on every rising edge
// where done is high and compared with the oldest queued expectation.
module tb_grid_height_model_vote_and_check_unit;

    localparam int ROWS   = 8;
    localparam int COLS   = 8;
    localparam int SETTLE = 16;
    localparam int NCELLS = ROWS * COLS;

    // An index past the register list; writes to it are dropped.
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [19:0] height;
    } check_result_t;

    int unsigned mismatch_count = 0;

    // Every mismatch goes through here so that it prints one line and counts.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Scoreboard: mirrors the learned grid and holds pending check results.
    class height_grid_scoreboard;
        logic [11:0]   fw, fh;
        logic [15:0]   lr, spread;
        logic [19:0]   heights[NCELLS];
        logic [7:0]    counts[NCELLS];
        bit            filled[NCELLS];
        check_result_t pending_checks[$];

        function new();
            fw = 12'd640; fh = 12'd480; lr = 16'd4096; spread = 16'd6554;
            for (int i = 0; i < NCELLS; i++)
            begin
                heights[i] = '0; counts[i] = '0; filled[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                ghm_pkg::CFG_FRAME_WIDTH:   fw = data[11:0];
                ghm_pkg::CFG_FRAME_HEIGHT:  fh = data[11:0];
                ghm_pkg::CFG_LEARNING_RATE: lr = data;
                ghm_pkg::CFG_HEIGHT_SPREAD: spread = data;
                default: ;
            endcase
        endfunction

        function void update_cell(int idx, longint unsigned hq);
            longint unsigned prev, mix, n;
            prev = heights[idx];
            if (!filled[idx])
            begin
                heights[idx] = hq[19:0];
                filled[idx] = 1'b1;
                if (counts[idx] < 255) counts[idx]++;
            end
            else if (counts[idx] > SETTLE)
            begin
                mix = longint'(lr) * hq + (65536 - longint'(lr)) * prev + 32768;
                heights[idx] = mix[35:16];
            end
            else
            begin
                if (counts[idx] < 255) counts[idx]++;
                n = counts[idx];
                mix = (hq + (n - 1) * prev + n / 2) / n;
                heights[idx] = mix[19:0];
            end
        endfunction

        // Notes one accepted command and, for a check, queues its result.
        function void note_command(logic op, logic [11:0] left, logic [11:0] top,
                                   logic [11:0] w, logic [11:0] h);
            longint unsigned hq, prev, n, d, lhs, rhs, tmp;
            int r, c, idx;
            check_result_t res;
            hq = longint'(h) << 8;
            if (fh == 0) r = ROWS - 1;
            else
            begin
                tmp = (longint'(top) + h) * ROWS / fh;
                r = (tmp > ROWS - 1) ? ROWS - 1 : int'(tmp);
            end
            if (fw == 0) c = COLS - 1;
            else
            begin
                tmp = (2 * longint'(left) + w) * COLS / (2 * longint'(fw));
                c = (tmp > COLS - 1) ? COLS - 1 : int'(tmp);
            end
            if (op == ghm_pkg::OP_VOTE)
            begin
                for (int i = -1; i < 2; i++)
                    for (int j = -1; j < 2; j++)
                    begin
                        int rr, cc;
                        rr = r + i; cc = c + j;
                        rr = rr < 0 ? 0 : (rr > ROWS - 1 ? ROWS - 1 : rr);
                        cc = cc < 0 ? 0 : (cc > COLS - 1 ? COLS - 1 : cc);
                        update_cell(rr * COLS + cc, hq);
                    end
            end
            else
            begin
                idx = r * COLS + c;
                if (!filled[idx])
                begin
                    res.verdict = ghm_pkg::VERDICT_NOT_SURE;
                    res.height = '0;
                end
                else
                begin
                    prev = heights[idx];
                    n = counts[idx];
                    d = prev > hq ? prev - hq : hq - prev;
                    lhs = d * n * 65536;
                    rhs = (3 * n + 10) * longint'(spread) * prev;
                    res.verdict = lhs < rhs ? ghm_pkg::VERDICT_GOOD : ghm_pkg::VERDICT_BAD;
                    res.height = prev[19:0];
                end
                pending_checks = {pending_checks, res};
            end
        endfunction

        task check_result(logic [1:0] v, logic [19:0] eh);
            check_result_t want;
            if (pending_checks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result v=%0d h=%0d", v, eh));
                return;
            end
            want = pending_checks.pop_front();
            if (v !== want.verdict)
                report_mismatch($sformatf("verdict %0d, want %0d", v, want.verdict));
            if (eh !== want.height)
                report_mismatch($sformatf("height %0d, want %0d", eh, want.height));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        opcode = 0;
    logic [11:0] box_left = '0, box_top = '0, box_width = 12'd1, box_height = 12'd1;
    wire         busy, done;
    wire  [1:0]  verdict;
    wire  [19:0] expected_height;

    height_grid_scoreboard grid_sb = new();

    grid_height_model_vote_and_check_unit #(
        .GRID_ROWS(ROWS), .GRID_COLS(COLS), .SETTLE_COUNT(SETTLE)
    ) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .opcode(opcode), .box_left(box_left), .box_top(box_top),
        .box_width(box_width), .box_height(box_height),
        .done(done), .verdict(verdict), .expected_height(expected_height)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Results cannot be held off, so each strobe is checked on its own edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            grid_sb.check_result(verdict, expected_height);
    end

    // Mostly short gaps, now and then a long one, often none at all.
    task automatic idle_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 40) return;
        else if (k < 92) repeat ($urandom_range(1, 4)) @(negedge clk);
        else repeat ($urandom_range(20, 120)) @(negedge clk);
    endtask

    // Drives one command and holds it until the transfer edge.
    task automatic send_command(logic op, logic [11:0] left, logic [11:0] top,
                                logic [11:0] w, logic [11:0] h);
        idle_gap();
        opcode = op; box_left = left; box_top = top;
        box_width = w; box_height = h;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        grid_sb.note_command(op, left, top, w, h);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Registers change only when nothing is in flight: all checks answered and
    // a vote's worst case allowed to drain.
    task automatic write_register(logic [2:0] idx, logic [15:0] data);
        while (grid_sb.pending_checks.size() != 0) @(negedge clk);
        repeat (260) @(negedge clk);
        cfg_index = idx; cfg_data = data; cfg_we = 1'b1;
        @(posedge clk);
        grid_sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random box: mostly a plausible person inside the frame, sometimes any bits.
    task automatic random_command(int unsigned vote_pct);
        logic op;
        logic [11:0] l, t, w, h;
        op = ($urandom_range(0, 99) < vote_pct) ? ghm_pkg::OP_VOTE : ghm_pkg::OP_CHECK;
        if ($urandom_range(0, 9) < 8)
        begin
            l = 12'($urandom_range(0, 700));
            t = 12'($urandom_range(0, 500));
            w = 12'($urandom_range(1, 120));
            h = 12'($urandom_range(20, 300));
        end
        else
        begin
            l = 12'($urandom); t = 12'($urandom);
            w = 12'($urandom_range(1, 4095));
            h = 12'($urandom_range(1, 4095));
        end
        send_command(op, l, t, w, h);
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: checks of empty cells, extremes, edge-clamped votes.
        send_command(ghm_pkg::OP_CHECK, 12'd0, 12'd0, 12'd1, 12'd1);
        send_command(ghm_pkg::OP_CHECK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_command(ghm_pkg::OP_VOTE, 12'd0, 12'd0, 12'd1, 12'd1);
        send_command(ghm_pkg::OP_CHECK, 12'd0, 12'd0, 12'd1, 12'd1);
        send_command(ghm_pkg::OP_VOTE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_command(ghm_pkg::OP_CHECK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_command(ghm_pkg::OP_CHECK, 12'd0, 12'd0, 12'd1, 12'd1000);
        // Repeated votes on one cell stay in the running-mean branch; then two checks.
        for (int i = 0; i < 10; i++)
            send_command(ghm_pkg::OP_VOTE, 12'd300, 12'd100, 12'd40, 12'd150 + 12'(i));
        send_command(ghm_pkg::OP_CHECK, 12'd300, 12'd100, 12'd40, 12'd152);
        send_command(ghm_pkg::OP_CHECK, 12'd300, 12'd100, 12'd40, 12'd40);

        // Zero frame size maps to the last row and column.
        write_register(ghm_pkg::CFG_FRAME_WIDTH, 16'd0);
        write_register(ghm_pkg::CFG_FRAME_HEIGHT, 16'd0);
        send_command(ghm_pkg::OP_VOTE, 12'd5, 12'd5, 12'd5, 12'd77);
        send_command(ghm_pkg::OP_CHECK, 12'd5, 12'd5, 12'd5, 12'd78);
        write_register(ghm_pkg::CFG_LEARNING_RATE, 16'hFFFF);
        write_register(ghm_pkg::CFG_HEIGHT_SPREAD, 16'hFFFF);
        write_register(CFG_UNUSED_INDEX, 16'h1234);

        // Random phases through several settings, extremes included.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin
                    write_register(ghm_pkg::CFG_FRAME_WIDTH, 16'd640);
                    write_register(ghm_pkg::CFG_FRAME_HEIGHT, 16'd480);
                end
                1: begin
                    write_register(ghm_pkg::CFG_LEARNING_RATE, 16'd0);
                    write_register(ghm_pkg::CFG_HEIGHT_SPREAD, 16'd0);
                end
                2: begin
                    write_register(ghm_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
                    write_register(ghm_pkg::CFG_FRAME_HEIGHT, 16'd1);
                end
                3: begin
                    write_register(ghm_pkg::CFG_FRAME_WIDTH, 16'd1);
                    write_register(ghm_pkg::CFG_FRAME_HEIGHT, 16'd4095);
                    write_register(ghm_pkg::CFG_LEARNING_RATE, 16'(($urandom)));
                end
                4: begin
                    write_register(ghm_pkg::CFG_FRAME_WIDTH,
                                   16'(($urandom_range(1, 4095))));
                    write_register(ghm_pkg::CFG_FRAME_HEIGHT,
                                   16'(($urandom_range(1, 4095))));
                    write_register(ghm_pkg::CFG_HEIGHT_SPREAD, 16'(($urandom)));
                end
                default: begin
                    write_register(ghm_pkg::CFG_FRAME_WIDTH, 16'd640);
                    write_register(ghm_pkg::CFG_FRAME_HEIGHT, 16'd480);
                    write_register(ghm_pkg::CFG_LEARNING_RATE, 16'd4096);
                    write_register(ghm_pkg::CFG_HEIGHT_SPREAD, 16'd6554);
                end
            endcase
            for (int i = 0; i < 65; i++)
                random_command(55);
        end

        // Drain: all checks answered, then let any trailing vote finish.
        while (grid_sb.pending_checks.size() != 0) @(negedge clk);
        repeat (260) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Worst case is roughly 420 items, each at its longest, plus long gaps and pauses.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
